[sv/cwf_pkg.sv]
// Shared types and constants of the 2D window convolution filter.
package cwf_pkg;

  localparam int PIX_W       = 8;
  localparam int COEF_W      = 12;
  localparam int COEF_ROWS   = 5;
  localparam int ROW_W       = 12;
  localparam int OCOL_W      = 10;
  localparam int VALUE_W     = 25;
  localparam int PSUM_W      = 24;
  localparam int SUM_W       = 26;
  localparam int CFG_W       = 60;
  localparam int CFG_AW      = 3;
  localparam int FW_W        = 11;
  localparam int FH_W        = 13;
  localparam int KS_W        = 3;
  localparam int MAX_HEIGHT  = 4096;
  localparam int FIFO_DEPTH  = 8;
  localparam int OUT_TDATA_W = 48;

  localparam int MAX_KERNEL_DEF = 5;
  localparam int MAX_WIDTH_DEF  = 1024;

  typedef enum logic [CFG_AW-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_KERNEL_SIZE  = 3'd2,
    REG_COEF_ROW_0   = 3'd3,
    REG_COEF_ROW_1   = 3'd4,
    REG_COEF_ROW_2   = 3'd5,
    REG_COEF_ROW_3   = 3'd6,
    REG_COEF_ROW_4   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic                      last;
    logic signed [VALUE_W-1:0] value;
    logic [OCOL_W-1:0]         col;
    logic [ROW_W-1:0]          row;
  } out_item_t;

endpackage

[sv/cwf_line_buf.sv]
// One row of the line store: single write port, registered read.
module cwf_line_buf #(
  parameter int DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [$clog2(DEPTH)-1:0]          wr_addr,
  input  logic [cwf_pkg::PIX_W-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0]          rd_addr,
  output logic [cwf_pkg::PIX_W-1:0]         rd_data
);
  import cwf_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[sv/cwf_cell.sv]
// Window column cell: holds one pixel column, passes it on, forms its column product sum.
module cwf_cell #(
  parameter int KC = 5
) (
  input  logic                                clk,
  input  logic                                shift_en,
  input  logic [cwf_pkg::PIX_W-1:0]           col_in  [KC],
  input  logic signed [cwf_pkg::COEF_W-1:0]   coef    [KC],
  output logic [cwf_pkg::PIX_W-1:0]           col_out [KC],
  output logic signed [cwf_pkg::PSUM_W-1:0]   psum
);
  import cwf_pkg::*;

  logic [PIX_W-1:0]         pix_r [KC];
  logic signed [PSUM_W-1:0] psum_r;
  logic signed [PSUM_W-1:0] psum_nxt;
  logic signed [PIX_W+COEF_W:0] prod;

  // drop taps outside the active kernel so stale or unwritten pixels never reach the sum
  always_comb begin
    psum_nxt = '0;
    prod     = '0;
    for (int i = 0; i < KC; i++) begin
      if (coef[i] != '0) begin
        prod = $signed({1'b0, pix_r[i]}) * coef[i];
      end else begin
        prod = '0;
      end
      psum_nxt = psum_nxt + PSUM_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      pix_r <= col_in;
    end
    psum_r <= psum_nxt;
  end

  assign col_out = pix_r;
  assign psum    = psum_r;

endmodule

[sv/cwf_fifo.sv]
// Output queue that decouples the pipeline from the result consumer.
module cwf_fifo #(
  parameter int DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  cwf_pkg::out_item_t  wr_data,
  input  logic                rd_en,
  output logic                not_empty,
  output cwf_pkg::out_item_t  rd_data
);
  import cwf_pkg::*;

  localparam int AW = $clog2(DEPTH);

  out_item_t        mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_en ? AW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = rd_en ? AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  assign not_empty = (count_r != '0);
  assign rd_data   = mem[rd_ptr_r];

endmodule

[sv/conv2d_window_filter.sv]
// k x k convolution over a raster pixel stream with line buffers and a chain of window cells.
// Takes one pixel per clock. Each pixel writes one line-buffer row and reads the same column
// of all rows; the column enters a chain of cells that form the window, each cell sums its
// column's products, and the column sums are added to give one result per interior
// position. Each result is registered through the line read, the cell pixels and the column
// sums, then waits in an eight-entry output queue; input stalls only when that queue's credit
// runs out. Border positions give no result.
module conv2d_window_filter #(
  parameter int MAX_KERNEL = cwf_pkg::MAX_KERNEL_DEF,
  parameter int MAX_WIDTH  = cwf_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // pixel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cwf_pkg::OUT_TDATA_W-1:0]   out_tdata,  // out_row, out_col, value, zero pad
  output logic                              out_tlast,
  input  logic                              cfg_wr_en,
  input  logic [cwf_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [cwf_pkg::CFG_W-1:0]         cfg_wr_data
);
  import cwf_pkg::*;

  localparam int KC0 = (MAX_KERNEL < COEF_ROWS) ? MAX_KERNEL : COEF_ROWS;
  localparam int KC  = (KC0 % 2 == 0) ? KC0 - 1 : KC0;
  localparam int RMW = (KC > 1) ? $clog2(KC) : 1;
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int FCW = $clog2(FIFO_DEPTH) + 1;

  // configuration
  logic [FW_W-1:0]   width_r;
  logic [FH_W-1:0]   height_r;
  logic [KS_W-1:0]   ksize_r;
  logic [CFG_W-1:0]  coef_rows_r [COEF_ROWS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= FW_W'(1024);
      height_r <= FH_W'(768);
      ksize_r  <= KS_W'(3);
      for (int r = 0; r < COEF_ROWS; r++) begin
        coef_rows_r[r] <= '0;
      end
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_FRAME_WIDTH:  width_r  <= cfg_wr_data[FW_W-1:0];
        REG_FRAME_HEIGHT: height_r <= cfg_wr_data[FH_W-1:0];
        REG_KERNEL_SIZE:  ksize_r  <= cfg_wr_data[KS_W-1:0];
        REG_COEF_ROW_0:   coef_rows_r[0] <= cfg_wr_data;
        REG_COEF_ROW_1:   coef_rows_r[1] <= cfg_wr_data;
        REG_COEF_ROW_2:   coef_rows_r[2] <= cfg_wr_data;
        REG_COEF_ROW_3:   coef_rows_r[3] <= cfg_wr_data;
        REG_COEF_ROW_4:   coef_rows_r[4] <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [KS_W-1:0] kk;
  logic [KS_W-1:0] km1;
  logic [CW:0]     eff_w;
  logic [FH_W-1:0] eff_h;

  always_comb begin
    kk = ksize_r;
    if (kk == '0) kk = KS_W'(1);
    if (!kk[0]) kk = kk - 1'b1;
    if (kk > KS_W'(KC)) kk = KS_W'(KC);
    km1 = kk - 1'b1;
    if (width_r == '0) begin
      eff_w = (CW+1)'(1);
    end else if (FH_W'(width_r) > FH_W'(MAX_WIDTH)) begin
      eff_w = (CW+1)'(MAX_WIDTH);
    end else begin
      eff_w = (CW+1)'(width_r);
    end
    if (height_r == '0) begin
      eff_h = FH_W'(1);
    end else if (height_r > FH_W'(MAX_HEIGHT)) begin
      eff_h = FH_W'(MAX_HEIGHT);
    end else begin
      eff_h = height_r;
    end
  end

  // coefficients laid out by cell (column offset) and row offset
  logic signed [COEF_W-1:0] coef_cell_r   [KC][KC];
  logic signed [COEF_W-1:0] coef_cell_nxt [KC][KC];
  logic [KS_W-1:0]          rsel, csel;

  always_comb begin
    rsel = '0;
    csel = '0;
    for (int j = 0; j < KC; j++) begin
      for (int i = 0; i < KC; i++) begin
        coef_cell_nxt[j][i] = '0;
        if (KS_W'(i) <= km1 && KS_W'(j) <= km1) begin
          rsel = km1 - KS_W'(i);
          csel = km1 - KS_W'(j);
          coef_cell_nxt[j][i] = $signed(coef_rows_r[rsel][COEF_W*csel +: COEF_W]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    coef_cell_r <= coef_cell_nxt;
  end

  // position counters
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [RMW-1:0]   rmod_r, rmod_nxt;
  logic [CW-1:0]    cc;
  logic [ROW_W-1:0] rr;
  logic             in_xfer;
  logic             emit;
  logic             last;
  logic [FCW-1:0]   credit_r, credit_nxt;
  logic             out_xfer;

  always_comb begin
    cc = ({1'b0, col_r} >= eff_w) ? CW'(eff_w - 1'b1) : col_r;
    rr = (FH_W'(row_r) >= eff_h) ? ROW_W'(eff_h - 1'b1) : row_r;
    emit = (rr >= ROW_W'(km1)) && ((CW+1)'(cc) >= (CW+1)'(km1));
    last = (FH_W'(rr) == eff_h - 1'b1) && ((CW+1)'(cc) == eff_w - 1'b1);
    col_nxt  = col_r;
    row_nxt  = row_r;
    rmod_nxt = rmod_r;
    if (in_xfer) begin
      if ((CW+1)'(cc) + 1'b1 >= eff_w) begin
        col_nxt = '0;
        if (FH_W'(rr) + 1'b1 >= eff_h) begin
          row_nxt  = '0;
          rmod_nxt = '0;
        end else begin
          row_nxt  = rr + 1'b1;
          rmod_nxt = (rmod_r == RMW'(KC - 1)) ? '0 : RMW'(rmod_r + 1'b1);
        end
      end else begin
        col_nxt = cc + 1'b1;
        row_nxt = rr;
      end
    end
    credit_nxt = credit_r + FCW'(in_xfer && emit) - FCW'(out_xfer);
  end

  assign in_tready = (credit_r < FCW'(FIFO_DEPTH));
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      rmod_r   <= '0;
      credit_r <= '0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      rmod_r   <= rmod_nxt;
      credit_r <= credit_nxt;
    end
  end

  // line store
  logic [PIX_W-1:0] rd_data [KC];

  for (genvar g = 0; g < KC; g++) begin : g_line
    cwf_line_buf #(
      .DEPTH(MAX_WIDTH)
    ) u_line (
      .clk     (clk),
      .wr_en   (in_xfer && (rmod_r == RMW'(g))),
      .wr_addr (cc),
      .wr_data (in_tdata),
      .rd_addr (cc),
      .rd_data (rd_data[g])
    );
  end

  // stage 1: read data back; valid, emit, last and position tags are registered alongside
  logic             v1_r, v2_r, v3_r;
  logic             emit1_r, emit2_r, emit3_r;
  logic             last1_r, last2_r, last3_r;
  logic [ROW_W-1:0] orow1_r, orow2_r, orow3_r;
  logic [OCOL_W-1:0] ocol1_r, ocol2_r, ocol3_r;
  logic [RMW-1:0]   rmod1_r;
  logic [PIX_W-1:0] pix1_r;
  logic [KS_W-1:0]  hh;

  assign hh = km1 >> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_xfer;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    emit1_r <= emit;
    last1_r <= last;
    orow1_r <= rr - ROW_W'(hh);
    ocol1_r <= OCOL_W'(cc - CW'(hh));
    rmod1_r <= rmod_r;
    pix1_r  <= in_tdata;
    emit2_r <= emit1_r;
    last2_r <= last1_r;
    orow2_r <= orow1_r;
    ocol2_r <= ocol1_r;
    emit3_r <= emit2_r;
    last3_r <= last2_r;
    orow3_r <= orow2_r;
    ocol3_r <= ocol2_r;
  end

  // column vector, newest row first
  logic [PIX_W-1:0] colv [KC];
  logic [RMW-1:0]   phys;

  always_comb begin
    phys = '0;
    colv[0] = pix1_r;
    for (int i = 1; i < KC; i++) begin
      if (rmod1_r >= RMW'(i)) begin
        phys = RMW'(rmod1_r - RMW'(i));
      end else begin
        phys = RMW'(rmod1_r + RMW'(KC - i));
      end
      colv[i] = rd_data[phys];
    end
  end

  // cell chain
  logic [PIX_W-1:0]         chain [KC+1][KC];
  logic signed [PSUM_W-1:0] psum  [KC];

  assign chain[0] = colv;

  for (genvar g = 0; g < KC; g++) begin : g_cell
    cwf_cell #(
      .KC(KC)
    ) u_cell (
      .clk      (clk),
      .shift_en (v1_r),
      .col_in   (chain[g]),
      .coef     (coef_cell_r[g]),
      .col_out  (chain[g+1]),
      .psum     (psum[g])
    );
  end

  // final sum and output queue
  logic signed [SUM_W-1:0] total;
  out_item_t               wr_item;
  out_item_t               rd_item;
  logic                    fifo_ne;

  always_comb begin
    total = '0;
    for (int j = 0; j < KC; j++) begin
      total = total + SUM_W'(psum[j]);
    end
    wr_item.last  = last3_r;
    wr_item.value = VALUE_W'(total);
    wr_item.col   = ocol3_r;
    wr_item.row   = orow3_r;
  end

  cwf_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (v3_r && emit3_r),
    .wr_data   (wr_item),
    .rd_en     (out_xfer),
    .not_empty (fifo_ne),
    .rd_data   (rd_item)
  );

  assign out_tvalid = fifo_ne;
  assign out_xfer   = out_tvalid && out_tready;
  assign out_tdata  = {1'b0, rd_item.value, rd_item.col, rd_item.row};
  assign out_tlast  = rd_item.last;

endmodule
